// File: hw/rtl/multi_channel_input_debouncer_defines.svh
// Assertion macros shared by the debouncer RTL.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef MULTI_CHANNEL_INPUT_DEBOUNCER_DEFINES_SVH
`define MULTI_CHANNEL_INPUT_DEBOUNCER_DEFINES_SVH

`ifndef SYNTHESIS
// Check that a property holds on every clock edge outside reset.
`define MCID_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("debouncer assertion failed");
// Check that a condition never occurs outside reset.
`define MCID_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("debouncer forbidden condition seen");
`else
`define MCID_ASSERT(lbl, prop)
`define MCID_ASSERT_NEVER(lbl, cond)
`endif

`endif

// File: hw/rtl/mcid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mcid_pkg;

  // Widths fixed by the register map and the request fields
  localparam int unsigned FIELD_W      = 4;
  localparam int unsigned DELAY_W      = 8;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 8;
  localparam int unsigned REG_CHANNELS = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_LOW = 3'd0,
    CFG_DELAY_CH0  = 3'd1,
    CFG_DELAY_CH1  = 3'd2,
    CFG_DELAY_CH2  = 3'd3,
    CFG_DELAY_CH3  = 3'd4
  } cfg_reg_e;

  // Per-lane request: take strobe, polarity-corrected level, delay setting
  typedef struct packed {
    logic               take;
    logic               level;
    logic [DELAY_W-1:0] delay;
  } lane_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/mcid_lane.sv
`timescale 1ns / 1ps
`default_nettype none

`include "multi_channel_input_debouncer_defines.svh"

module mcid_lane #(
  parameter int unsigned COUNT_BITS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mcid_pkg::lane_req_t req_i,
  output logic                    qual_next_o
);

  localparam int unsigned WideW =
    (COUNT_BITS > mcid_pkg::DELAY_W) ? COUNT_BITS : mcid_pkg::DELAY_W;
  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  logic                  cand_q, cand_d;
  logic                  qual_q, qual_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [COUNT_BITS-1:0] cnt_dec;
  logic [COUNT_BITS-1:0] cnt_load;
  logic [WideW-1:0]      delay_wide;
  logic [WideW-1:0]      cnt_max_wide;

  // Saturate the reload value at the counter range
  assign delay_wide   = WideW'(req_i.delay);
  assign cnt_max_wide = WideW'(CntMax);
  assign cnt_load     = (delay_wide > cnt_max_wide) ? CntMax : COUNT_BITS'(delay_wide);

  // Count down toward zero, hold at zero
  assign cnt_dec = (cnt_q != '0) ? cnt_q - COUNT_BITS'(1) : cnt_q;

  // Qualify a stable level, pass through with zero delay, or restart
  always_comb begin
    cand_d = cand_q;
    cnt_d  = cnt_q;
    qual_d = qual_q;
    if (req_i.level == cand_q) begin
      cnt_d = cnt_dec;
      if (cnt_dec == '0) begin
        qual_d = req_i.level;
      end
    end else if (req_i.delay == '0) begin
      qual_d = req_i.level;
    end else begin
      cnt_d  = cnt_load;
      cand_d = req_i.level;
    end
  end

  assign qual_next_o = qual_d;

  // Advance lane state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= 1'b0;
      cnt_q  <= '0;
      qual_q <= 1'b0;
    end else if (req_i.take) begin
      cand_q <= cand_d;
      cnt_q  <= cnt_d;
      qual_q <= qual_d;
    end
  end

  // Last stable tick of a running count must qualify the level
  `MCID_ASSERT(a_lane_qualify,
    req_i.take && (req_i.level == cand_q) && (cnt_q == COUNT_BITS'(1))
      |=> qual_q == $past(req_i.level))
  // Candidate moves only on an accepted request with a nonzero delay
  `MCID_ASSERT(a_lane_cand_change,
    (cand_q != $past(cand_q)) |-> ($past(req_i.take) && ($past(req_i.delay) != '0)))

endmodule

`default_nettype wire

// File: hw/rtl/mcid_merge.sv
`timescale 1ns / 1ps
`default_nettype none

`include "multi_channel_input_debouncer_defines.svh"

module mcid_merge (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        take_i,
  input  wire logic [mcid_pkg::FIELD_W-1:0] levels_i,
  output logic                             busy_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [mcid_pkg::FIELD_W-1:0]     out_levels_o
);

  logic                           out_valid_q, out_valid_d;
  logic [mcid_pkg::FIELD_W-1:0]   out_data_q, out_data_d;
  logic                           skid_valid_q, skid_valid_d;
  logic [mcid_pkg::FIELD_W-1:0]   skid_data_q, skid_data_d;
  logic                           out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Refill the output from the skid stage first, else park a new result
  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (out_free) begin
      skid_valid_d = 1'b0;
      if (skid_valid_q) begin
        out_valid_d = 1'b1;
        out_data_d  = skid_data_q;
      end else begin
        out_valid_d = take_i;
        out_data_d  = levels_i;
      end
    end else if (take_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = levels_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign busy_o       = skid_valid_q;
  assign out_valid_o  = out_valid_q;
  assign out_levels_o = out_data_q;

  // Skid stage is only ever filled behind a held output
  `MCID_ASSERT_NEVER(a_merge_skid_alone, skid_valid_q && !out_valid_q)
  // A request taken against a stalled output lands in the skid stage
  `MCID_ASSERT(a_merge_park, take_i && !out_free |=> skid_valid_q)
  // No request is taken while the skid stage is full
  `MCID_ASSERT_NEVER(a_merge_overrun, take_i && skid_valid_q)

endmodule

`default_nettype wire

// File: hw/rtl/multi_channel_input_debouncer.sv
// Multi-channel input debouncer.
// Input channel: in_valid_i / in_stall_o carry one scan tick of raw pin levels
// (raw_levels_i, bit n is channel n). A request is taken at a clock edge with
// in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i carry the debounced levels after
// that tick (debounced_levels_o), one result per request, in order.
// Config channel: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// index 0 is the active-low mask, indexes 1 to 4 the per-channel delays.
// Write it only while no request is in flight. cfg_ready_o is always high.
// Results are registered at the merge output. One request per cycle is
// sustained unless the receiver stalls; each channel lane does its compare
// and count-down combinationally. If the receiver stalls, one more request
// is parked in a skid stage and then in_stall_o stays high until the held
// result is taken. Reset zeroes the config registers, counters, candidates
// and debounced levels and empties the output channel, but not its data.
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_input_debouncer #(
  parameter int unsigned CHANNELS   = 4,
  parameter int unsigned COUNT_BITS = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [mcid_pkg::FIELD_W-1:0]   raw_levels_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [mcid_pkg::FIELD_W-1:0]        debounced_levels_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [mcid_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [mcid_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // Channels beyond the register map never leave zero and are not built
  localparam int unsigned Lanes =
    (CHANNELS < mcid_pkg::REG_CHANNELS) ? CHANNELS : mcid_pkg::REG_CHANNELS;

  logic                                          take;
  logic                                          merge_busy;
  logic                                          mask_we;
  logic [mcid_pkg::REG_CHANNELS-1:0]             delay_we;
  logic [Lanes-1:0]                              mask_q;
  logic [Lanes-1:0][mcid_pkg::DELAY_W-1:0]       delay_q;
  logic [mcid_pkg::FIELD_W-1:0]                  lane_qual;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = merge_busy;
  assign take        = in_valid_i && !merge_busy;

  // Decode register writes
  always_comb begin
    mask_we  = 1'b0;
    delay_we = '0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mcid_pkg::CFG_ACTIVE_LOW: mask_we     = 1'b1;
        mcid_pkg::CFG_DELAY_CH0:  delay_we[0] = 1'b1;
        mcid_pkg::CFG_DELAY_CH1:  delay_we[1] = 1'b1;
        mcid_pkg::CFG_DELAY_CH2:  delay_we[2] = 1'b1;
        mcid_pkg::CFG_DELAY_CH3:  delay_we[3] = 1'b1;
        default: ;
      endcase
    end
  end

  // Hold the polarity mask
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (mask_we) begin
      mask_q <= cfg_data_i[Lanes-1:0];
    end
  end

  // Hold the per-channel delays
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= '0;
    end else begin
      for (int unsigned i = 0; i < Lanes; i++) begin
        if (delay_we[i]) begin
          delay_q[i] <= cfg_data_i[mcid_pkg::DELAY_W-1:0];
        end
      end
    end
  end

  // One lane per channel with its delay register
  for (genvar ch = 0; ch < mcid_pkg::FIELD_W; ch++) begin : g_lane
    if (ch < Lanes) begin : g_on
      mcid_pkg::lane_req_t req;

      assign req.take  = take;
      assign req.level = raw_levels_i[ch] ^ mask_q[ch];
      assign req.delay = delay_q[ch];

      mcid_lane #(
        .COUNT_BITS (COUNT_BITS)
      ) u_lane (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .req_i       (req),
        .qual_next_o (lane_qual[ch])
      );
    end else begin : g_off
      assign lane_qual[ch] = 1'b0;
    end
  end

  // Gather lane levels into one result
  mcid_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .levels_i     (lane_qual),
    .busy_o       (merge_busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_levels_o (debounced_levels_o)
  );

endmodule

`default_nettype wire
